// ----- sv/cxeq_pkg.sv -----
// Shared constants, types and helper functions for the crossover band equaliser.
// No dependencies; the equaliser top level imports this package.
`timescale 1ns / 1ps
`default_nettype none

package cxeq_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int XO_STAGES   = 3;
  localparam int NUM_BQ      = 3 * XO_STAGES;
  localparam int SLOT_SMOOTH = 3 * NUM_BQ;
  localparam int SLOT_GAIN   = SLOT_SMOOTH + 3;
  localparam int NUM_SLOTS   = SLOT_GAIN + 4;
  localparam int SLOT_W      = 6;
  localparam int STG_W       = $clog2(XO_STAGES + 1);
  localparam int BQ_W        = $clog2(NUM_BQ);
  localparam int SIG_W       = 40;
  localparam int COEF_W      = 32;
  localparam int MC_W        = 34;
  localparam int PROD_W      = 76;
  localparam int RND_W       = 48;

  localparam logic signed [RND_W-1:0] SIG_MAX = RND_W'((64'sd1 <<< (SIG_W - 1)) - 64'sd1);
  localparam logic signed [RND_W-1:0] SIG_MIN = RND_W'(-(64'sd1 <<< (SIG_W - 1)));
  localparam logic signed [SIG_W-1:0] SMP_MAX = SIG_W'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
  localparam logic signed [SIG_W-1:0] SMP_MIN = SIG_W'(-(64'sd1 <<< (SAMPLE_W - 1)));
  localparam logic signed [MC_W-1:0]  COEF_ONE = MC_W'(64'sd1 <<< 28);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MLO,
    ST_MHI,
    ST_WB,
    ST_FIN
  } state_t;

  typedef enum logic {
    ACT_WRITE  = 1'b0,
    ACT_SAMPLE = 1'b1
  } action_t;

  function automatic logic signed [SIG_W-1:0] sat40(input logic signed [RND_W-1:0] v);
    logic signed [SIG_W-1:0] r;
    if (v > SIG_MAX) r = SIG_MAX[SIG_W-1:0];
    else if (v < SIG_MIN) r = SIG_MIN[SIG_W-1:0];
    else r = v[SIG_W-1:0];
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_smp(input logic signed [SIG_W-1:0] v);
    logic signed [SIG_W-1:0] r;
    if (v > SMP_MAX) r = SMP_MAX;
    else if (v < SMP_MIN) r = SMP_MIN;
    else r = v;
    return r[SAMPLE_W-1:0];
  endfunction

  // coefficient slot used by a given step; band 3 is the remix
  function automatic logic [SLOT_W-1:0] slot_of(input logic [STG_W-1:0] stg,
                                                input logic [1:0] bnd, input logic [1:0] op);
    int s;
    if (bnd == 2'd3) s = SLOT_GAIN + int'(op);
    else if (int'(stg) == XO_STAGES) s = SLOT_SMOOTH + int'(bnd);
    else s = 9 * int'(stg) + 3 * int'(bnd) + int'(op);
    return SLOT_W'(s);
  endfunction

endpackage

`default_nettype wire

// ----- sv/cxeq_ram.sv -----
// Generic single write, single read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cxeq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 34
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- sv/cascaded_crossover_band_eq.sv -----
// Four-band crossover equaliser: one shared 40x18 multiplier under a step sequencer.
// Coefficient write items are taken in the idle state, which the sequencer does not leave.
// A sample item takes 49 multiply steps, each a low half, high half and write-back state,
// then an output state that waits while a held result is not yet taken. No new item is
// taken until the sample has gone back to idle; throughput is set by the one multiplier.
// Synchronous reset clears control, filter state and coefficient valid bits (store reads zero).
// Depends on cxeq_pkg and cxeq_ram.
`timescale 1ns / 1ps
`default_nettype none

module cascaded_crossover_band_eq
  import cxeq_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       req_valid,
  output logic                            req_ready,
  input  wire logic                       action,
  input  wire logic [5:0]                 coef_index,
  input  wire logic signed [COEF_W-1:0]   coef_value,
  input  wire logic signed [SAMPLE_W-1:0] sample_in,
  output logic                            rsp_valid,
  input  wire logic                       rsp_ready,
  output logic signed [SAMPLE_W-1:0]      sample_out
);

  state_t state, state_next;
  logic [STG_W-1:0] stage, stage_next;
  logic [1:0]       band, band_next, op, op_next;
  logic             seq_done;
  logic             do_lo, do_hi, do_wb, out_load;

  logic signed [SIG_W-1:0] bnd [4];
  logic signed [SIG_W-1:0] y;
  logic signed [SIG_W-1:0] s1 [NUM_BQ];
  logic signed [SIG_W-1:0] s2 [NUM_BQ];
  logic signed [SIG_W-1:0] sm [3];
  logic signed [RND_W-1:0] pa, pa2, acc;
  logic signed [PROD_W-1:0] p;

  logic [NUM_SLOTS-1:0] vld;
  logic                 rvld;
  logic [COEF_W-1:0]    rdata;
  logic [SLOT_W-1:0]    raddr;
  logic                 cwe;

  logic                    accept;
  logic                    is_sm, is_mix, op_last;
  logic [BQ_W-1:0]         bq;
  logic signed [SIG_W-1:0] mx;
  logic signed [MC_W-1:0]  cs, mc;
  logic signed [17:0]      mcp;
  logic signed [57:0]      prod;
  logic signed [49:0]      t1;
  logic signed [50:0]      t2;
  logic signed [RND_W-1:0] rnd1, rnd2;
  logic signed [SIG_W-1:0] sm_new, split_src;

  assign accept = req_valid && req_ready;
  assign cwe    = accept && (action == ACT_WRITE) && (int'(coef_index) < NUM_SLOTS);

  cxeq_ram #(.WIDTH(COEF_W), .DEPTH(NUM_SLOTS)) u_coef (
    .clk   (clk),
    .we    (cwe),
    .waddr (coef_index),
    .wdata (coef_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign is_sm   = (int'(stage) == XO_STAGES);
  assign is_mix  = (band == 2'd3);
  assign bq      = BQ_W'(3 * int'(stage) + int'(band));
  assign op_last = is_mix ? (op == 2'd3) : (is_sm ? (op == 2'd1) : (op == 2'd2));

  // multiplier operands
  always_comb begin
    if (is_mix) mx = bnd[op];
    else if (is_sm) mx = (op == 2'd0) ? sm[band] : bnd[band];
    else mx = (op == 2'd0) ? bnd[band] : y;
  end

  assign cs = rvld ? MC_W'($signed(rdata)) : '0;
  assign mc = (is_sm && !is_mix && op == 2'd1) ? COEF_ONE - cs : cs;

  // low half unsigned, high half signed, through the one multiplier
  assign mcp  = do_hi ? {mc[MC_W-1], mc[MC_W-1:17]} : {1'b0, mc[16:0]};
  assign prod = mx * mcp;

  // round half up of p/2^28 and 2p/2^28
  assign t1   = {p[PROD_W-1], p[PROD_W-1:27]} + 50'sd1;
  assign t2   = {p[PROD_W-1], p[PROD_W-1:26]} + 51'sd1;
  assign rnd1 = t1[RND_W:1];
  assign rnd2 = t2[RND_W:1];

  assign sm_new    = sat40(pa + rnd1);
  assign split_src = bnd[band];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept && action == ACT_SAMPLE) state_next = ST_MLO;
      ST_MLO:  state_next = ST_MHI;
      ST_MHI:  state_next = ST_WB;
      ST_WB:   state_next = seq_done ? ST_FIN : ST_MLO;
      ST_FIN:  if (!rsp_valid || rsp_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_ready = (state == ST_IDLE) && !rst;
    do_lo     = (state == ST_MLO);
    do_hi     = (state == ST_MHI);
    do_wb     = (state == ST_WB);
    out_load  = (state == ST_FIN) && (!rsp_valid || rsp_ready);
  end

  // step counters
  always_comb begin
    stage_next = stage;
    band_next  = band;
    op_next    = op;
    seq_done   = 1'b0;
    if (do_wb) begin
      if (!op_last) begin
        op_next = op + 2'd1;
      end else begin
        op_next = 2'd0;
        if (!is_mix) begin
          band_next = band + 2'd1;
        end else begin
          band_next = 2'd0;
          if (is_sm) begin
            stage_next = '0;
            seq_done   = 1'b1;
          end else begin
            stage_next = stage + STG_W'(1);
          end
        end
      end
    end
  end

  assign raddr = slot_of(stage_next, band_next, op_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      stage     <= '0;
      band      <= '0;
      op        <= '0;
      rsp_valid <= 1'b0;
      vld       <= '0;
      rvld      <= 1'b0;
      for (int i = 0; i < NUM_BQ; i++) begin
        s1[i] <= '0;
        s2[i] <= '0;
      end
      for (int i = 0; i < 3; i++) sm[i] <= '0;
    end else begin
      state <= state_next;
      stage <= stage_next;
      band  <= band_next;
      op    <= op_next;
      rvld  <= vld[raddr];
      if (cwe) vld[coef_index] <= 1'b1;
      if (out_load) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
      if (do_wb && !is_mix) begin
        if (is_sm) begin
          if (op == 2'd1) sm[band] <= sm_new;
        end else begin
          if (op == 2'd1) s1[bq] <= sat40(pa2 - rnd1 + RND_W'(s2[bq]));
          if (op == 2'd2) s2[bq] <= sat40(pa - rnd1);
        end
      end
    end
  end

  // datapath payload
  always_ff @(posedge clk) begin
    if (accept && action == ACT_SAMPLE) bnd[0] <= SIG_W'(sample_in);
    if (do_lo) p <= {{(PROD_W-58){prod[57]}}, prod};
    if (do_hi) p <= p + {{(PROD_W-75){prod[57]}}, prod, 17'b0};
    if (do_wb) begin
      if (is_mix) begin
        if (op == 2'd0) acc <= rnd1;
        else acc <= acc + rnd1;
        if (op_last) bnd[0] <= sat40(acc + rnd1);
      end else if (is_sm) begin
        if (op == 2'd0) pa <= rnd1;
        else begin
          bnd[band + 2'd1] <= sm_new;
          bnd[band]        <= sat40(RND_W'(split_src) - RND_W'(sm_new));
        end
      end else begin
        unique case (op)
          2'd0: begin
            y   <= sat40(rnd1 + RND_W'(s1[bq]));
            pa  <= rnd1;
            pa2 <= rnd2;
          end
          2'd2: begin
            bnd[band + 2'd1] <= y;
            bnd[band]        <= sat40(RND_W'(split_src) - RND_W'(y));
          end
          default: ;
        endcase
      end
    end
    if (out_load) sample_out <= sat_smp(bnd[0]);
  end

endmodule

`default_nettype wire
